@@ rtl/sdt_pkg.sv @@
// Shared types, codes and helpers for the SAT decision trail block.
// No dependencies; used by sat_decision_trail_core.
package sdt_pkg;

	// operation codes carried in the input item's tuser
	localparam logic [2:0] KIND_PUSH  = 3'd0;
	localparam logic [2:0] KIND_QUERY = 3'd1;
	localparam logic [2:0] KIND_SET   = 3'd2;
	localparam logic [2:0] KIND_POP   = 3'd3;
	localparam logic [2:0] KIND_BT    = 3'd4;

	// assignment values
	localparam logic [1:0] VAL_UNK   = 2'd0;
	localparam logic [1:0] VAL_FALSE = 2'd1;
	localparam logic [1:0] VAL_TRUE  = 2'd2;
	localparam logic [1:0] VAL_BAD   = 2'd3;

	// result status
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam int VAR_W   = 10;
	localparam int LEVEL_W = 11;

	// one trail level
	typedef struct packed {
		logic             flipped;
		logic [1:0]       val;
		logic [VAR_W-1:0] var_id;
	} trail_entry_t;

	localparam int ENTRY_W = $bits(trail_entry_t);

	// value code three reads as unknown
	function automatic logic [1:0] norm_value(input logic [1:0] v);
		return (v == VAL_BAD) ? VAL_UNK : v;
	endfunction

	// true <-> false, unknown stays
	function automatic logic [1:0] swap_value(input logic [1:0] v);
		logic [1:0] r;
		r = v;
		if (v == VAL_TRUE)
			r = VAL_FALSE;
		else if (v == VAL_FALSE)
			r = VAL_TRUE;
		return r;
	endfunction

endpackage

@@ rtl/sdt_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/sat_decision_trail_core.sv @@
// Top level of the SAT decision trail: assignment table, decision trail and sequencer.
// Depends on sdt_pkg and sdt_ram.
//
// Assignment table and decision trail of a DPLL-style SAT solver with
// chronological backtracking. Each input item is one operation (tuser = kind:
// push decision, query literal, set assignment, pop, backtrack) and yields
// exactly one result item with the queried literal value, the trail depth, the
// top decision and a status. Both stores are simple dual-port RAMs with a
// registered read; a small sequencer walks each operation through them and the
// block takes one item at a time (s_tready is high only while the sequencer is
// idle). A push, set, failed operation or unused kind goes straight from the
// exec step to finish; a query also waits for the table read; a pop clears
// the table entry, then waits for one trail read to fetch the new top (skipped
// when it empties the trail); and a backtrack pops every level above the
// target, each clearing its table entry and then reading the next top from
// the trail RAM, before it flips the top decision. After reset the assignment
// table is cleared to unknown, one entry a cycle, so the block accepts no item
// until every entry is cleared. A finished result sits in the output register
// and the next item is accepted meanwhile; the sequencer only waits if a second
// result is ready before the first is taken.
module sat_decision_trail_core #(
	parameter int MAX_VARS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// [9:0] var_index, [11:10] value, [12] lit_negated, [23:13] target_level
	input  logic [23:0] s_tdata,
	// [2:0] kind
	input  logic [2:0]  s_tuser,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] lit_value, [12:2] depth_now, [22:13] top_var, [24:23] top_value,
	// [25] top_flipped, [27:26] status, [31:28] zero
	output logic [31:0] m_tdata
);

	localparam int VAR_AW = $clog2(MAX_VARS);      // table address bits
	localparam int TAW    = $clog2(MAX_VARS);      // trail address bits
	localparam int LW     = $clog2(MAX_VARS + 1);  // level counter bits
	localparam int CMP_W  = 17;                    // covers var, level, target

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_QWAIT,
		S_POP,
		S_POPWAIT,
		S_FLIP,
		S_FINISH
	} state_t;

	state_t state_q;

	// latched item
	logic [2:0]                  kind_q;
	logic [sdt_pkg::VAR_W-1:0]   var_q;
	logic [1:0]                  val_q;
	logic                        neg_q;
	logic [sdt_pkg::LEVEL_W-1:0] target_q;

	// architectural state and result staging
	logic [LW-1:0]         lc_q;
	sdt_pkg::trail_entry_t top_q;
	logic [1:0]            lit_q;
	logic [1:0]            status_q;
	logic [VAR_AW-1:0]     clr_q;
	logic                  m_tvalid_q;
	logic [31:0]           m_tdata_q;

	// RAM ports
	logic                  tab_we, tab_re;
	logic [VAR_AW-1:0]     tab_waddr, tab_raddr;
	logic [1:0]            tab_wdata, tab_rdata;
	logic                  trl_we, trl_re;
	logic [TAW-1:0]        trl_waddr, trl_raddr;
	sdt_pkg::trail_entry_t trl_wdata, trl_rdata;

	// derived terms
	logic [CMP_W-1:0]  var_ext, top_ext;
	logic [VAR_AW-1:0] var_addr, top_addr;
	logic [LW-1:0]     lc_m1, lc_m2;
	logic              var_ok, full, empty, above_target;
	logic              res_load;

	assign var_ext      = CMP_W'(var_q);
	assign top_ext      = CMP_W'(top_q.var_id);
	assign var_addr     = var_ext[VAR_AW-1:0];
	assign top_addr     = top_ext[VAR_AW-1:0];
	assign var_ok       = var_ext < CMP_W'(MAX_VARS);
	assign lc_m1        = lc_q - LW'(1);
	assign lc_m2        = lc_q - LW'(2);
	assign full         = lc_q == LW'(MAX_VARS);
	assign empty        = lc_q == '0;
	assign above_target = CMP_W'(lc_q) > CMP_W'(target_q);
	// result register free or being emptied this cycle
	assign res_load     = (state_q == S_FINISH) && (!m_tvalid_q || m_tready);

	// RAM control from the sequencer state
	always_comb begin
		tab_we    = 1'b0;
		tab_waddr = var_addr;
		tab_wdata = val_q;
		tab_re    = 1'b0;
		tab_raddr = var_addr;
		trl_we    = 1'b0;
		trl_waddr = lc_q[TAW-1:0];
		trl_wdata = '{flipped: 1'b0, val: val_q, var_id: var_q};
		trl_re    = 1'b0;
		trl_raddr = lc_m2[TAW-1:0];
		unique case (state_q)
			S_CLEAR: begin
				tab_we    = 1'b1;
				tab_waddr = clr_q;
				tab_wdata = sdt_pkg::VAL_UNK;
			end
			S_EXEC: begin
				unique case (kind_q)
					sdt_pkg::KIND_PUSH: begin
						tab_we = var_ok && !full;
						trl_we = var_ok && !full;
					end
					sdt_pkg::KIND_QUERY: tab_re = var_ok;
					sdt_pkg::KIND_SET:   tab_we = var_ok;
					default: ;
				endcase
			end
			S_POP: begin
				// clear the dropped variable, fetch the level below it
				tab_we    = 1'b1;
				tab_waddr = top_addr;
				tab_wdata = sdt_pkg::VAL_UNK;
				trl_re    = lc_q != LW'(1);
			end
			S_FLIP: begin
				tab_we    = 1'b1;
				tab_waddr = top_addr;
				tab_wdata = sdt_pkg::swap_value(top_q.val);
				trl_we    = 1'b1;
				trl_waddr = lc_m1[TAW-1:0];
				trl_wdata = '{flipped: 1'b1, val: sdt_pkg::swap_value(top_q.val),
				              var_id: top_q.var_id};
			end
			default: ;
		endcase
	end

	sdt_ram #(.WIDTH(2), .DEPTH(MAX_VARS)) u_assign_table (
		.clk   (clk),
		.we    (tab_we),
		.waddr (tab_waddr),
		.wdata (tab_wdata),
		.re    (tab_re),
		.raddr (tab_raddr),
		.rdata (tab_rdata)
	);

	sdt_ram #(.WIDTH(sdt_pkg::ENTRY_W), .DEPTH(MAX_VARS)) u_trail_store (
		.clk   (clk),
		.we    (trl_we),
		.waddr (trl_waddr),
		.wdata (trl_wdata),
		.re    (trl_re),
		.raddr (trl_raddr),
		.rdata (trl_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			lc_q       <= '0;
			top_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_load)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + VAR_AW'(1);
					if (clr_q == VAR_AW'(MAX_VARS - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q   <= s_tuser;
						var_q    <= s_tdata[9:0];
						val_q    <= sdt_pkg::norm_value(s_tdata[11:10]);
						neg_q    <= s_tdata[12];
						target_q <= s_tdata[23:13];
						lit_q    <= sdt_pkg::VAL_UNK;
						status_q <= sdt_pkg::ST_OK;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FINISH;
					unique case (kind_q)
						sdt_pkg::KIND_PUSH: begin
							if (!var_ok) begin
								status_q <= sdt_pkg::ST_BAD;
							end else if (full) begin
								status_q <= sdt_pkg::ST_FULL;
							end else begin
								lc_q  <= lc_q + LW'(1);
								top_q <= '{flipped: 1'b0, val: val_q, var_id: var_q};
							end
						end
						sdt_pkg::KIND_QUERY: begin
							if (!var_ok)
								status_q <= sdt_pkg::ST_BAD;
							else
								state_q <= S_QWAIT;
						end
						sdt_pkg::KIND_SET: begin
							if (!var_ok)
								status_q <= sdt_pkg::ST_BAD;
						end
						sdt_pkg::KIND_POP: begin
							if (empty)
								status_q <= sdt_pkg::ST_BAD;
							else
								state_q <= S_POP;
						end
						sdt_pkg::KIND_BT: begin
							if (empty || target_q == '0)
								status_q <= sdt_pkg::ST_BAD;
							else if (above_target)
								state_q <= S_POP;
							else
								state_q <= S_FLIP;
						end
						default: ;
					endcase
				end
				S_QWAIT: begin
					lit_q   <= neg_q ? sdt_pkg::swap_value(tab_rdata) : tab_rdata;
					state_q <= S_FINISH;
				end
				S_POP: begin
					lc_q <= lc_m1;
					// last level gone: nothing to fetch
					if (lc_q == LW'(1))
						state_q <= S_FINISH;
					else
						state_q <= S_POPWAIT;
				end
				S_POPWAIT: begin
					top_q <= trl_rdata;
					if (kind_q == sdt_pkg::KIND_POP)
						state_q <= S_FINISH;
					else if (above_target)
						state_q <= S_POP;
					else
						state_q <= S_FLIP;
				end
				S_FLIP: begin
					top_q.val     <= sdt_pkg::swap_value(top_q.val);
					top_q.flipped <= 1'b1;
					state_q       <= S_FINISH;
				end
				S_FINISH: begin
					// hold here only if the previous result is still pending
					if (res_load) begin
						m_tdata_q  <= {4'b0, status_q,
						               empty ? 1'b0 : top_q.flipped,
						               empty ? 2'b0 : top_q.val,
						               empty ? {sdt_pkg::VAR_W{1'b0}} : top_q.var_id,
						               sdt_pkg::LEVEL_W'(lc_q),
						               lit_q};
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// flip always lands on a live level
	a_flip_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLIP) |-> (lc_q != '0))
		else $error("flip on empty trail");

	// depth moves by at most one level per cycle
	a_depth_step: assert property (@(posedge clk) disable iff (!arst_n)
		(lc_q != $past(lc_q)) |->
		(lc_q == $past(lc_q) + LW'(1) || lc_q == $past(lc_q) - LW'(1)))
		else $error("depth jumped");

	// depth never passes capacity
	a_depth_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(lc_q) <= CMP_W'(MAX_VARS))
		else $error("depth above capacity");

	// a result is only raised by the finish step
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> ($past(state_q) == S_FINISH))
		else $error("result raised outside finish");

endmodule
